@@ rtl/core/sfd_pkg.sv @@
`timescale 1ns / 1ps

package sfd_pkg;

	typedef enum logic [3:0] {
		PH_HUNT   = 4'd0,
		PH_DEST   = 4'd1,
		PH_SRC    = 4'd2,
		PH_TYPE   = 4'd3,
		PH_LENHI  = 4'd4,
		PH_LENLO  = 4'd5,
		PH_DATA   = 4'd6,
		PH_FRAMES = 4'd7,
		PH_SEQ    = 4'd8,
		PH_PAD    = 4'd9,
		PH_CHK1   = 4'd10,
		PH_CHK2   = 4'd11
	} sfd_phase_t;

	localparam logic [1:0] EV_BYTE = 2'd0;
	localparam logic [1:0] EV_GOOD = 2'd1;
	localparam logic [1:0] EV_FAIL = 2'd2;

	localparam logic [1:0] CFG_FRAME_ID = 2'd0;
	localparam logic [1:0] CFG_DEST     = 2'd1;
	localparam logic [1:0] CFG_SRC      = 2'd2;

	localparam logic [7:0] RST_FRAME_ID = 8'h1E;
	localparam logic [7:0] RST_DEST     = 8'h0C;
	localparam logic [7:0] RST_SRC      = 8'h00;

	typedef struct packed {
		logic [7:0] frame_id;
		logic [7:0] destination;
		logic [7:0] source;
	} sfd_cfg_t;

	typedef struct packed {
		logic [1:0]  event_kind;
		logic [7:0]  byte_value;
		logic [15:0] byte_index;
		logic [7:0]  message_type;
		logic [15:0] payload_length;
		logic [7:0]  frames_remaining;
		logic [7:0]  sequence_number;
	} sfd_event_t;

	typedef struct packed {
		logic       valid;
		sfd_event_t ev;
	} sfd_res_t;

endpackage

@@ rtl/core/sfd_if.sv @@
`timescale 1ns / 1ps

interface sfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_event_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_kind;
	logic [7:0]  byte_value;
	logic [15:0] byte_index;
	logic [7:0]  message_type;
	logic [15:0] payload_length;
	logic [7:0]  frames_remaining;
	logic [7:0]  sequence_number;

	modport source (output valid, output event_kind, output byte_value, output byte_index,
		output message_type, output payload_length, output frames_remaining,
		output sequence_number, input ready);
	modport sink (input valid, input event_kind, input byte_value, input byte_index,
		input message_type, input payload_length, input frames_remaining,
		input sequence_number, output ready);
endinterface

@@ rtl/core/serial_frame_deframer_xor_check.sv @@
`timescale 1ns / 1ps

// channel  dir  handshake       payload
// rx       in   valid / ready   rx_byte
// ev       out  valid / ready   event_kind, byte_value, byte_index, message_type,
//                               payload_length, frames_remaining, sequence_number
// cfg      in   cfg_we          cfg_index, cfg_data
//
// One byte per cycle unless the result register is stalled: a byte is held in the
// input register, and the parser state and (for payload and final check bytes) the
// result register update together on the edge that moves it on.
// Reset puts the parser in the hunt and loads the default frame id,
// destination and source. A stalled result register holds the input register;
// rx takes a new byte whenever the input register is empty or moves on.

module serial_frame_deframer_xor_check import sfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sfd_byte_if.sink    rx,
	sfd_event_if.source ev,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	sfd_cfg_t   cfg_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       go;
	sfd_res_t   res;
	logic       out_valid_q;
	sfd_event_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_id    <= RST_FRAME_ID;
			cfg_q.destination <= RST_DEST;
			cfg_q.source      <= RST_SRC;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_ID: cfg_q.frame_id    <= cfg_data;
				CFG_DEST:     cfg_q.destination <= cfg_data;
				CFG_SRC:      cfg_q.source      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign go       = valid_s1 && (!out_valid_q || ev.ready);
	assign rx.ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	sfd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (go),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (ev.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && res.valid) begin
			out_q <= res.ev;
		end
	end

	assign ev.valid            = out_valid_q;
	assign ev.event_kind       = out_q.event_kind;
	assign ev.byte_value       = out_q.byte_value;
	assign ev.byte_index       = out_q.byte_index;
	assign ev.message_type     = out_q.message_type;
	assign ev.payload_length   = out_q.payload_length;
	assign ev.frames_remaining = out_q.frames_remaining;
	assign ev.sequence_number  = out_q.sequence_number;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !ev.ready) |-> !go)
		else $error("result register overwritten while stalled");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !go) |=> (valid_s1 && $stable(byte_s1)))
		else $error("input register lost a byte during stall");

	a_result_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(go && res.valid) |=> out_valid_q)
		else $error("result not loaded");

endmodule

@@ rtl/core/sfd_parser.sv @@
`timescale 1ns / 1ps

module sfd_parser import sfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	input  sfd_cfg_t   cfg,
	output sfd_res_t   res
);

	sfd_phase_t  phase_q, phase_d;
	logic [7:0]  sum_even_q, sum_even_d;
	logic [7:0]  sum_odd_q, sum_odd_d;
	logic [7:0]  type_q, type_d;
	logic [15:0] len_q, len_d;
	logic [15:0] pos_q, pos_d;
	logic [7:0]  frames_q, frames_d;
	logic [7:0]  seq_q, seq_d;
	logic [15:0] raw_len;
	logic [15:0] pos_inc;
	logic        fold_en;
	logic        fold_odd;

	assign raw_len = {len_q[15:8], rx_byte};
	assign pos_inc = pos_q + 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			sum_even_q <= '0;
			sum_odd_q  <= '0;
			type_q     <= '0;
			len_q      <= '0;
			pos_q      <= '0;
			frames_q   <= '0;
			seq_q      <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			sum_even_q <= sum_even_d;
			sum_odd_q  <= sum_odd_d;
			type_q     <= type_d;
			len_q      <= len_d;
			pos_q      <= pos_d;
			frames_q   <= frames_d;
			seq_q      <= seq_d;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		type_d   = type_q;
		len_d    = len_q;
		pos_d    = pos_q;
		frames_d = frames_q;
		seq_d    = seq_q;
		fold_en  = 1'b0;
		fold_odd = 1'b0;
		sum_even_d = sum_even_q;
		sum_odd_d  = sum_odd_q;
		res.valid               = 1'b0;
		res.ev.event_kind       = EV_BYTE;
		res.ev.byte_value       = '0;
		res.ev.byte_index       = '0;
		res.ev.message_type     = type_q;
		res.ev.payload_length   = len_q;
		res.ev.frames_remaining = '0;
		res.ev.sequence_number  = '0;
		unique case (phase_q)
			PH_DEST: begin
				if (rx_byte == cfg.destination) begin
					fold_en  = 1'b1;
					fold_odd = 1'b1;
					phase_d  = PH_SRC;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_SRC: begin
				if (rx_byte == cfg.source) begin
					fold_en = 1'b1;
					phase_d = PH_TYPE;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_TYPE: begin
				type_d   = rx_byte;
				fold_en  = 1'b1;
				fold_odd = 1'b1;
				phase_d  = PH_LENHI;
			end
			PH_LENHI: begin
				len_d   = {rx_byte, 8'h00};
				fold_en = 1'b1;
				phase_d = PH_LENLO;
			end
			PH_LENLO: begin
				len_d    = (raw_len >= 16'd2) ? raw_len - 16'd2 : 16'd0;
				fold_en  = 1'b1;
				fold_odd = 1'b1;
				pos_d    = '0;
				phase_d  = (len_d != 16'd0) ? PH_DATA : PH_FRAMES;
			end
			PH_DATA: begin
				fold_en   = 1'b1;
				fold_odd  = pos_q[0];
				res.valid = 1'b1;
				res.ev.byte_value = rx_byte;
				res.ev.byte_index = pos_q;
				pos_d = pos_inc;
				if (pos_inc >= len_q) begin
					phase_d = PH_FRAMES;
				end
			end
			PH_FRAMES: begin
				frames_d = rx_byte;
				fold_en  = 1'b1;
				fold_odd = len_q[0];
				phase_d  = PH_SEQ;
			end
			PH_SEQ: begin
				seq_d    = rx_byte;
				fold_en  = 1'b1;
				fold_odd = ~len_q[0];
				phase_d  = len_q[0] ? PH_PAD : PH_CHK1;
			end
			PH_PAD: begin
				fold_en  = 1'b1;
				fold_odd = len_q[0];
				phase_d  = PH_CHK1;
			end
			PH_CHK1: begin
				fold_en = 1'b1;
				phase_d = PH_CHK2;
			end
			PH_CHK2: begin
				res.valid = 1'b1;
				res.ev.event_kind = (sum_even_q == 8'h00 && sum_odd_q == rx_byte) ?
					EV_GOOD : EV_FAIL;
				res.ev.frames_remaining = frames_q;
				res.ev.sequence_number  = seq_q;
				phase_d = PH_HUNT;
			end
			default: begin
				if (rx_byte == cfg.frame_id) begin
					sum_even_d = rx_byte;
					sum_odd_d  = '0;
					type_d     = '0;
					len_d      = '0;
					pos_d      = '0;
					frames_d   = '0;
					seq_d      = '0;
					phase_d    = PH_DEST;
				end else begin
					phase_d = PH_HUNT;
				end
			end
		endcase
		if (fold_en) begin
			if (fold_odd) begin
				sum_odd_d = sum_odd_q ^ rx_byte;
			end else begin
				sum_even_d = sum_even_q ^ rx_byte;
			end
		end
	end

	a_chk2_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q == PH_CHK2) |=> (phase_q == PH_HUNT))
		else $error("checksum phase did not return to hunt");

	a_data_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q == PH_DATA && pos_inc < len_q) |=>
		(phase_q == PH_DATA && pos_q == $past(pos_inc)))
		else $error("payload run ended early");

	a_result_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (phase_q == PH_DATA || phase_q == PH_CHK2))
		else $error("result outside payload or final check");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (pos_q < len_q))
		else $error("payload index beyond length");

endmodule
